// ----- src/mary_upper_bound_search_unit_defines.svh -----
// Assertion macros shared by the checker of the upper-bound search unit.
`ifndef MARY_UPPER_BOUND_SEARCH_UNIT_DEFINES_SVH
`define MARY_UPPER_BOUND_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MUBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MUBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- src/mubs_pkg.sv -----
// Shared widths and request codes of the upper-bound search unit.
package mubs_pkg;

  localparam int KEY_W  = 32;
  localparam int ADDR_W = 10;
  localparam int CNT_W  = 11;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- src/mubs_in_if.sv -----
// Request channel of the upper-bound search unit.
interface mubs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic        [mubs_pkg::ADDR_W-1:0] address;
  logic signed [mubs_pkg::KEY_W-1:0]  value;

  modport source (output valid, kind, address, value, input ready);
  modport sink (input valid, kind, address, value, output ready);
endinterface

// ----- src/mubs_out_if.sv -----
// Result channel of the upper-bound search unit.
interface mubs_out_if;
  logic                        valid;
  logic                        ready;
  logic [mubs_pkg::CNT_W-1:0]  position;
  logic                        empty_table;

  modport source (output valid, position, empty_table, input ready);
  modport sink (input valid, position, empty_table, output ready);
endinterface

// ----- src/mubs_cfg_if.sv -----
// Configuration write channel of the upper-bound search unit.
interface mubs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mubs_pkg::CNT_W-1:0]  entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

// ----- src/mary_upper_bound_search_unit.sv -----
// Top level of the m-ary upper-bound search unit.
//
// Usage: requests arrive on in_req. A write request (kind write) stores value at
// address in the key table and gives no result; addresses at or beyond DEPTH are
// dropped. A query request (kind query) returns on out_rsp the count of leading
// entries not greater than value, searched over the first entry_count entries
// (clamped to DEPTH). entry_count comes from cfg_wr, always ready; write it only
// while the unit is idle. Keys must be ascending and written before any query.
// Timing: after a write in_req stays ready. A query holds in_req not ready
// until its result is loaded into the output register. Each search round
// computes the stride with a multiply (ST_DIV), then reads one probe at a time
// (ST_CMP), as the key RAM has a single read port. An empty table skips the
// search and answers with empty_table set. The result register holds while
// out_rsp is stalled; writes are still taken while idle, and the next query
// is searched but waits in ST_FIN for the register.
// Reset clears entry_count and the control state; the key table is not cleared.
module mary_upper_bound_search_unit #(
  parameter int DEPTH  = 1024,
  parameter int FANOUT = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  mubs_in_if.sink           in_req,
  mubs_out_if.source        out_rsp,
  mubs_cfg_if.sink          cfg_wr
);

  localparam int CW      = mubs_pkg::CNT_W;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIVISOR = FANOUT - 1;
  localparam int SH      = CW + $clog2(DIVISOR);
  localparam int RECIP_W = CW + 1;
  localparam int PW      = CW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SH) + DIVISOR - 1) / DIVISOR);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic signed [mubs_pkg::KEY_W-1:0] key_r;
  logic [CW-1:0]                     lo_r, lo_nxt;
  logic [CW-1:0]                     end_r, end_nxt;
  logic [CW-1:0]                     stride_r, stride_nxt;
  logic [CW-1:0]                     probe_r, probe_nxt;
  logic [CW-1:0]                     pass_r, pass_nxt;
  logic [CW-1:0]                     res_pos_r, res_pos_nxt;
  logic                              res_empty_r, res_empty_nxt;
  logic [CW-1:0]                     entry_count_r;
  logic                              out_valid_r;
  logic [CW-1:0]                     out_pos_r;
  logic                              out_empty_r;

  logic [CW-1:0]                     cnt_eff;
  logic [CW-1:0]                     n_less;
  logic [PW-1:0]                     prod;
  logic [CW-1:0]                     step;
  logic [CW:0]                       nxt_probe;
  logic [CW-1:0]                     probe_inc;
  logic [CW-1:0]                     rd_addr;
  logic [mubs_pkg::KEY_W-1:0]        rd_data;
  logic                              key_pass;
  logic                              wr_en;
  logic                              in_fire;
  logic                              out_free;

  assign in_req.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.position    = out_pos_r;
  assign out_rsp.empty_table = out_empty_r;

  assign cnt_eff   = (32'(entry_count_r) > 32'(DEPTH)) ? CW'(DEPTH) : entry_count_r;
  assign n_less    = end_r - lo_r - 1'b1;
  assign prod      = PW'(n_less) * PW'(RECIP);
  assign step      = (stride_r == '0) ? CW'(1) : stride_r;
  assign nxt_probe = {1'b0, probe_r} + {1'b0, step};
  assign probe_inc = probe_r + 1'b1;
  assign key_pass  = $signed(rd_data) <= key_r;
  assign wr_en     = in_fire && (in_req.kind == mubs_pkg::KIND_WRITE)
                     && (32'(in_req.address) < 32'(DEPTH));

  mubs_ram #(
    .WIDTH (mubs_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_req.address)),
    .wdata ($unsigned(in_req.value)),
    .raddr (AW'(rd_addr)),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    stride_nxt    = stride_r;
    probe_nxt     = probe_r;
    pass_nxt      = pass_r;
    res_pos_nxt   = res_pos_r;
    res_empty_nxt = res_empty_r;
    rd_addr       = lo_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid && (in_req.kind == mubs_pkg::KIND_QUERY)) begin
          if (cnt_eff == '0) begin
            res_pos_nxt   = '0;
            res_empty_nxt = 1'b1;
            state_nxt     = ST_FIN;
          end else begin
            lo_nxt        = '0;
            end_nxt       = cnt_eff;
            res_empty_nxt = 1'b0;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        stride_nxt = CW'(prod >> SH);
        probe_nxt  = lo_r;
        pass_nxt   = lo_r;
        rd_addr    = lo_r;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        rd_addr = nxt_probe[CW-1:0];
        if (key_pass) begin
          if (nxt_probe < {1'b0, end_r}) begin
            probe_nxt = nxt_probe[CW-1:0];
            pass_nxt  = probe_inc;
          end else if ((stride_r == '0) || (probe_inc == end_r)) begin
            res_pos_nxt = probe_inc;
            state_nxt   = ST_FIN;
          end else begin
            lo_nxt    = probe_inc;
            state_nxt = ST_DIV;
          end
        end else begin
          if ((stride_r <= CW'(1)) || (pass_r == lo_r)) begin
            res_pos_nxt = pass_r;
            state_nxt   = ST_FIN;
          end else begin
            lo_nxt    = pass_r;
            end_nxt   = pass_r + stride_r - 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        entry_count_r <= cfg_wr.entry_count;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_req.value;
    end
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    stride_r    <= stride_nxt;
    probe_r     <= probe_nxt;
    pass_r      <= pass_nxt;
    res_pos_r   <= res_pos_nxt;
    res_empty_r <= res_empty_nxt;
    if ((state_r == ST_FIN) && out_free) begin
      out_pos_r   <= res_pos_r;
      out_empty_r <= res_empty_r;
    end
  end

endmodule

// ----- src/mubs_ram.sv -----
// Generic simple dual-port RAM with registered read.
module mubs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mubs_checker.sv -----
// Port-level checker of the upper-bound search unit and its bind.
`include "mary_upper_bound_search_unit_defines.svh"

module mubs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mubs_pkg::CNT_W-1:0] out_position,
  input logic                       out_empty_table
);

  `MUBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_position) && $stable(out_empty_table))
  `MUBS_ASSERT_NOW(a_empty_zero, out_valid && out_empty_table, out_position == '0)
  `MUBS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (in_kind == mubs_pkg::KIND_QUERY), !in_ready)
  `MUBS_ASSERT_NEXT(a_write_ready, in_valid && in_ready && (in_kind == mubs_pkg::KIND_WRITE), in_ready)

endmodule

bind mary_upper_bound_search_unit mubs_checker u_mubs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .in_kind         (in_req.kind),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_position    (out_rsp.position),
  .out_empty_table (out_rsp.empty_table)
);

// ----- test/tb_mary_upper_bound_search_unit.sv -----
// Self-checking testbench for the m-ary upper-bound search unit.
`timescale 1ns / 1ps

module tb_mary_upper_bound_search_unit;

  localparam int DEPTH = 1024;
  localparam int FANOUT = 33;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MIXED_ITEMS = 700;
  localparam logic signed [mubs_pkg::KEY_W-1:0] KEY_MIN =
    {1'b1, {(mubs_pkg::KEY_W-1){1'b0}}};
  localparam logic signed [mubs_pkg::KEY_W-1:0] KEY_MAX =
    {1'b0, {(mubs_pkg::KEY_W-1){1'b1}}};

  typedef struct packed {
    logic [mubs_pkg::CNT_W-1:0] position;
    logic                       empty_table;
  } bound_result_t;

  typedef enum logic {ROW_REQUEST, ROW_COUNT} row_op_t;

  typedef struct packed {
    row_op_t                            op;
    logic                               kind;
    logic [mubs_pkg::ADDR_W-1:0]        address;
    logic signed [mubs_pkg::KEY_W-1:0]  value;
    bit                                 typed;
    bound_result_t                      result;
  } bound_row_t;

  localparam bound_result_t NO_RES = '{'0, 1'b0};

  bound_row_t dir_rows [0:21] = '{
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, KEY_MIN, 1'b1, '{11'd0, 1'b1}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd1023, KEY_MAX, 1'b1, '{11'd0, 1'b1}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'h2AA, 32'sd0, 1'b1, '{11'd0, 1'b1}},
    '{ROW_REQUEST, mubs_pkg::KIND_WRITE, 10'd0, KEY_MIN, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_WRITE, 10'd1, -32'sd1, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_WRITE, 10'd2, 32'sd0, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_WRITE, 10'd3, KEY_MAX, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_WRITE, 10'd1023, 32'sh5555_5555, 1'b0, NO_RES},
    '{ROW_COUNT, mubs_pkg::KIND_WRITE, 10'd0, 32'sd4, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd1023, KEY_MIN, 1'b1, '{11'd1, 1'b0}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, KEY_MAX, 1'b1, '{11'd4, 1'b0}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'h155, -32'sd1, 1'b1, '{11'd2, 1'b0}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, -32'sd2, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, 32'sd0, 1'b1, '{11'd3, 1'b0}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, 32'sh7FFF_FFFE, 1'b0, NO_RES},
    '{ROW_COUNT, mubs_pkg::KIND_WRITE, 10'd0, 32'sd1, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, KEY_MAX, 1'b1, '{11'd1, 1'b0}},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, KEY_MIN + 32'sd1, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_WRITE, 10'd0, KEY_MAX, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, 32'sd0, 1'b0, NO_RES},
    '{ROW_COUNT, mubs_pkg::KIND_WRITE, 10'd0, 32'sd0, 1'b0, NO_RES},
    '{ROW_REQUEST, mubs_pkg::KIND_QUERY, 10'd0, -32'sd1, 1'b1, '{11'd0, 1'b1}}
  };

  int unsigned count_plan [] = '{1024, 2047, 1023, 0, 1, 2, 3, 31, 32, 33, 34, 65, 66, 97,
                                 200, 512};

  logic clk;
  logic rst_n;

  mubs_in_if  req ();
  mubs_out_if rsp ();
  mubs_cfg_if cfg ();

  mary_upper_bound_search_unit #(
    .DEPTH  (DEPTH),
    .FANOUT (FANOUT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req),
    .out_rsp (rsp),
    .cfg_wr  (cfg)
  );

  logic signed [mubs_pkg::KEY_W-1:0] key_table [DEPTH];
  bit                                key_seen [DEPTH];
  logic [mubs_pkg::CNT_W-1:0]        entry_limit = '0;
  bound_result_t                     pending_bounds [$];
  bound_result_t                     oldest_bound;
  int unsigned                       send_idle_pct = 18;
  int unsigned                       stall_pct = 81;
  int unsigned                       quiet_cycles = 0;
  bit                                run_failed = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bound_result_t upper_bound(
    input logic signed [mubs_pkg::KEY_W-1:0] key);
    int unsigned lo, n, stride, hits, step, i;
    bit failed;
    bound_result_t res;
    n = (entry_limit > DEPTH) ? DEPTH : entry_limit;
    lo = 0;
    res.empty_table = (n == 0);
    while (n > 0) begin
      stride = (n - 1) / (FANOUT - 1);
      hits = 0;
      failed = 1'b0;
      if (stride == 0) begin
        while (hits < n && key_table[lo + hits] <= key) hits++;
        lo += hits;
        n = 0;
      end else begin
        for (i = lo; i < lo + n && !failed; i += stride) begin
          if (key_table[i] <= key) hits++;
          else failed = 1'b1;
        end
        if (hits == 0) begin
          n = 0;
        end else begin
          step = 1 + (hits - 1) * stride;
          lo += step;
          n = failed ? stride - 1 : n - step;
        end
      end
    end
    res.position = mubs_pkg::CNT_W'(lo);
    return res;
  endfunction

  function automatic logic signed [mubs_pkg::KEY_W-1:0] pick_key(input int unsigned span);
    int unsigned roll;
    logic signed [mubs_pkg::KEY_W-1:0] near;
    roll = $urandom_range(0, 99);
    if (span == 0 || roll < 10) return $urandom;
    near = key_table[$urandom_range(0, span - 1)];
    if (roll < 50) return near;
    if (roll < 65) return near + 1;
    if (roll < 80) return near - 1;
    if (roll < 87) return key_table[0] - 1;
    if (roll < 94) return key_table[span - 1] + 1;
    return roll[0] ? KEY_MAX : KEY_MIN;
  endfunction

  task automatic send_request(input logic kind, input logic [mubs_pkg::ADDR_W-1:0] addr,
                              input logic signed [mubs_pkg::KEY_W-1:0] key,
                              input bit typed, input bound_result_t typed_res);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.kind    <= kind;
    req.address <= addr;
    req.value   <= key;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (kind == mubs_pkg::KIND_WRITE) begin
      key_table[addr] = key;
      key_seen[addr] = 1'b1;
    end else begin
      pending_bounds.push_back(typed ? typed_res : upper_bound(key));
    end
  endtask

  task automatic set_entry_count(input logic [mubs_pkg::CNT_W-1:0] count);
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg.valid       <= 1'b1;
    cfg.entry_count <= count;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    entry_limit = count;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_keys(input int unsigned span, input bit ordered);
    longint acc;
    int unsigned gap_cap;
    logic signed [mubs_pkg::KEY_W-1:0] key;
    case ($urandom_range(0, 3))
      0: acc = KEY_MIN;
      1: acc = -longint'($urandom_range(0, 4000));
      2: acc = longint'(KEY_MAX) - longint'($urandom_range(0, 200));
      default: acc = longint'($signed($urandom));
    endcase
    gap_cap = $urandom_range(0, 1) ? 3 : (1 << $urandom_range(4, 24));
    for (int unsigned a = 0; a < span; a++) begin
      if (ordered) key = (acc > KEY_MAX) ? KEY_MAX : acc[mubs_pkg::KEY_W-1:0];
      else key = $urandom;
      send_request(mubs_pkg::KIND_WRITE, mubs_pkg::ADDR_W'(a), key, 1'b0, NO_RES);
      acc += $urandom_range(0, gap_cap);
    end
  endtask

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      if (pending_bounds.size() == 0) begin
        $display("%0t: unexpected result, expected none, got position %0d empty %0b",
                 $time, rsp.position, rsp.empty_table);
        run_failed = 1'b1;
      end else begin
        oldest_bound = pending_bounds.pop_front();
        if (rsp.position !== oldest_bound.position ||
            rsp.empty_table !== oldest_bound.empty_table) begin
          $display("%0t: mismatch, expected position %0d empty %0b, got position %0d empty %0b",
                   $time, oldest_bound.position, oldest_bound.empty_table,
                   rsp.position, rsp.empty_table);
          run_failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned mixed_sent, plan_idx, count, span, roll, rounds;
    bit fresh;
    mixed_sent = 0;
    plan_idx = 0;
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.kind = mubs_pkg::KIND_WRITE;
    req.address = '0;
    req.value = '0;
    cfg.valid = 1'b0;
    cfg.entry_count = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].op == ROW_COUNT) begin
        set_entry_count(dir_rows[r].value[mubs_pkg::CNT_W-1:0]);
      end else begin
        send_request(dir_rows[r].kind, dir_rows[r].address, dir_rows[r].value,
                     dir_rows[r].typed, dir_rows[r].result);
      end
    end

    while (mixed_sent < MIXED_ITEMS) begin
      if (plan_idx < count_plan.size()) begin
        count = count_plan[plan_idx];
        plan_idx++;
      end else begin
        roll = $urandom_range(0, 99);
        count = (roll < 10) ? 0 : (roll < 20) ? $urandom_range(900, 2047) :
                $urandom_range(1, 140);
      end
      set_entry_count(mubs_pkg::CNT_W'(count));
      span = (count > DEPTH) ? DEPTH : count;
      fresh = 1'b0;
      for (int unsigned a = 0; a < span; a++) if (!key_seen[a]) fresh = 1'b1;
      if (fresh || (span > 0 && span <= 256 && $urandom_range(0, 1)))
        load_keys(span, $urandom_range(0, 99) < 85);
      rounds = (span >= 512) ? 12 : 30;
      repeat (rounds) begin
        send_idle_pct = (mixed_sent < MIXED_ITEMS / 3) ? 18 :
                        (mixed_sent < 2 * MIXED_ITEMS / 3) ? 81 : 0;
        stall_pct = (mixed_sent < MIXED_ITEMS / 3) ? 81 :
                    (mixed_sent < 2 * MIXED_ITEMS / 3) ? 18 : 0;
        roll = $urandom_range(0, 99);
        if (roll < 8 && span < DEPTH)
          send_request(mubs_pkg::KIND_WRITE,
                       mubs_pkg::ADDR_W'($urandom_range(span, DEPTH - 1)), $urandom,
                       1'b0, NO_RES);
        else if (roll < 12 && span > 0)
          send_request(mubs_pkg::KIND_WRITE,
                       mubs_pkg::ADDR_W'($urandom_range(0, span - 1)), $urandom,
                       1'b0, NO_RES);
        else
          send_request(mubs_pkg::KIND_QUERY, mubs_pkg::ADDR_W'($urandom), pick_key(span),
                       1'b0, NO_RES);
        mixed_sent++;
      end
    end

    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!run_failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/mubs_pkg.sv
src/mubs_in_if.sv
src/mubs_out_if.sv
src/mubs_cfg_if.sv
src/mubs_ram.sv
src/mary_upper_bound_search_unit.sv
src/mubs_checker.sv
test/tb_mary_upper_bound_search_unit.sv
